// ----- rtl/slp_pkg.sv -----
package slp_pkg;

    // Table geometry and field widths.
    localparam int SECTION_COUNT = 16;
    localparam int SECTION_W     = 4;
    localparam int CNT_W         = 32;
    localparam int TOTAL_W       = 64;

    // Operation codes carried in the operation field.
    localparam logic [1:0] OP_RECORD = 2'd0;
    localparam logic [1:0] OP_READ   = 2'd1;
    localparam logic [1:0] OP_CLEAR  = 2'd2;

    // Slow-call thresholds in microseconds.
    localparam logic [CNT_W-1:0] THRESH_50MS   = 32'd50000;
    localparam logic [CNT_W-1:0] THRESH_100MS  = 32'd100000;
    localparam logic [CNT_W-1:0] THRESH_500MS  = 32'd500000;
    localparam logic [CNT_W-1:0] THRESH_1000MS = 32'd1000000;

    // The divider retires two quotient bits per cycle.
    localparam int DIV_STEPS = TOTAL_W / 2;
    localparam int DIV_CNT_W = $clog2(DIV_STEPS);

endpackage

// ----- rtl/slp_if.sv -----
// Request channel: one operation word per handshake.
interface slp_req_if;
    logic                              valid;
    logic                              ready;
    logic [1:0]                        operation;
    logic [slp_pkg::SECTION_W-1:0]     section;
    logic [slp_pkg::CNT_W-1:0]         start_us;
    logic [slp_pkg::CNT_W-1:0]         now_us;

    modport source (output valid, operation, section, start_us, now_us, input ready);
    modport sink   (input valid, operation, section, start_us, now_us, output ready);
endinterface

// Response channel: one statistics word per read.
interface slp_rsp_if;
    logic                              valid;
    logic                              ready;
    logic [slp_pkg::SECTION_W-1:0]     read_section;
    logic [slp_pkg::CNT_W-1:0]         call_count;
    logic [slp_pkg::TOTAL_W-1:0]       total_time;
    logic [slp_pkg::CNT_W-1:0]         max_time;
    logic [slp_pkg::CNT_W-1:0]         avg_time;
    logic [slp_pkg::CNT_W-1:0]         slow_50ms;
    logic [slp_pkg::CNT_W-1:0]         slow_100ms;
    logic [slp_pkg::CNT_W-1:0]         slow_500ms;
    logic [slp_pkg::CNT_W-1:0]         slow_1000ms;

    modport source (output valid, read_section, call_count, total_time, max_time, avg_time,
                    slow_50ms, slow_100ms, slow_500ms, slow_1000ms, input ready);
    modport sink   (input valid, read_section, call_count, total_time, max_time, avg_time,
                    slow_50ms, slow_100ms, slow_500ms, slow_1000ms, output ready);
endinterface

// ----- rtl/section_latency_profiler_top.sv -----
// Section latency profiler. Each request word is a record, a read or a clear, and the
// block takes one word at a time. A record computes the elapsed time when it is taken
// and updates the section's counters in the following cycle; a record that is ignored
// (profiling disabled, zero start, or section out of range), a clear and an unknown
// operation leave the block idle. A read fetches the entry, runs the radix-4 restoring
// divider that forms the average (total over calls, 64 by 32 bits, two quotient bits
// per cycle), and loads the response register; it skips the divider when the section
// has no calls. The divider sets the read rate. The response register holds a finished
// result while the next request is taken; a read only waits in its last cycle while
// that register is still full. Clear resets all the per-entry valid bits at once, so no
// sweep is needed after reset or clear. The enabled register resets to 1 and gates
// records only.
module section_latency_profiler_top (
    input  logic               clk,
    input  logic               rst_n,
    slp_req_if.sink            req,
    slp_rsp_if.source          rsp,
    input  logic               cfg_we,
    input  logic               cfg_wdata
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_REC_UPD,
        S_RD_LOAD,
        S_DIV,
        S_FIN
    } state_t;

    localparam int CW = slp_pkg::CNT_W;
    localparam int TW = slp_pkg::TOTAL_W;
    localparam int SW = slp_pkg::SECTION_W;
    localparam int SN = slp_pkg::SECTION_COUNT;

    // Statistics tables, one entry per section.
    logic [CW-1:0] calls_mem [SN];
    logic [TW-1:0] total_mem [SN];
    logic [CW-1:0] max_mem   [SN];
    logic [CW-1:0] s50_mem   [SN];
    logic [CW-1:0] s100_mem  [SN];
    logic [CW-1:0] s500_mem  [SN];
    logic [CW-1:0] s1000_mem [SN];

    // Control and datapath registers.
    state_t                 state_reg, state_next;
    logic                   enabled_reg, enabled_next;
    logic [SN-1:0]          valid_reg, valid_next;
    logic [SW-1:0]          sec_reg, sec_next;
    logic [CW-1:0]          el_reg, el_next;
    logic [CW-1:0]          st_calls_reg, st_calls_next;
    logic [TW-1:0]          st_total_reg, st_total_next;
    logic [CW-1:0]          st_max_reg, st_max_next;
    logic [CW-1:0]          st_s50_reg, st_s50_next;
    logic [CW-1:0]          st_s100_reg, st_s100_next;
    logic [CW-1:0]          st_s500_reg, st_s500_next;
    logic [CW-1:0]          st_s1000_reg, st_s1000_next;
    logic [CW-1:0]          rem_reg, rem_next;
    logic [TW-1:0]          quo_reg, quo_next;
    logic [slp_pkg::DIV_CNT_W-1:0] cnt_reg, cnt_next;

    logic                   out_valid_reg, out_valid_next;
    logic [SW-1:0]          out_sec_reg, out_sec_next;
    logic [CW-1:0]          out_calls_reg, out_calls_next;
    logic [TW-1:0]          out_total_reg, out_total_next;
    logic [CW-1:0]          out_max_reg, out_max_next;
    logic [CW-1:0]          out_avg_reg, out_avg_next;
    logic [CW-1:0]          out_s50_reg, out_s50_next;
    logic [CW-1:0]          out_s100_reg, out_s100_next;
    logic [CW-1:0]          out_s500_reg, out_s500_next;
    logic [CW-1:0]          out_s1000_reg, out_s1000_next;

    // Entry lookup and update terms.
    logic                   req_fire;
    logic                   req_in_range;
    logic                   sec_in_range;
    logic                   hit;
    logic [CW-1:0]          cur_calls, cur_max, cur_s50, cur_s100, cur_s500, cur_s1000;
    logic [TW-1:0]          cur_total;
    logic                   wr_en;

    // Divider step terms.
    logic [CW:0]            div_r1, div_r2, div_d;
    logic                   div_ge1, div_ge2;
    logic [CW-1:0]          div_s1, div_s2;

    assign req.ready = (state_reg == S_IDLE);
    assign req_fire  = req.valid && req.ready;

    assign req_in_range = ({{(32 - SW){1'b0}}, req.section} < 32'(SN));
    assign sec_in_range = ({{(32 - SW){1'b0}}, sec_reg} < 32'(SN));
    assign hit          = sec_in_range && valid_reg[sec_reg];

    // An entry that is not valid reads as zero.
    always_comb
    begin
        cur_calls = '0;
        cur_total = '0;
        cur_max   = '0;
        cur_s50   = '0;
        cur_s100  = '0;
        cur_s500  = '0;
        cur_s1000 = '0;
        if (hit)
        begin
            cur_calls = calls_mem[sec_reg];
            cur_total = total_mem[sec_reg];
            cur_max   = max_mem[sec_reg];
            cur_s50   = s50_mem[sec_reg];
            cur_s100  = s100_mem[sec_reg];
            cur_s500  = s500_mem[sec_reg];
            cur_s1000 = s1000_mem[sec_reg];
        end
    end

    assign wr_en = (state_reg == S_REC_UPD);

    // Two restoring division steps per cycle.
    assign div_d   = {1'b0, st_calls_reg};
    assign div_r1  = {rem_reg, quo_reg[TW-1]};
    assign div_ge1 = (div_r1 >= div_d);
    assign div_s1  = div_ge1 ? CW'(div_r1 - div_d) : div_r1[CW-1:0];
    assign div_r2  = {div_s1, quo_reg[TW-2]};
    assign div_ge2 = (div_r2 >= div_d);
    assign div_s2  = div_ge2 ? CW'(div_r2 - div_d) : div_r2[CW-1:0];

    // Sequencer and next-value logic.
    always_comb
    begin
        state_next     = state_reg;
        enabled_next   = enabled_reg;
        valid_next     = valid_reg;
        sec_next       = sec_reg;
        el_next        = el_reg;
        st_calls_next  = st_calls_reg;
        st_total_next  = st_total_reg;
        st_max_next    = st_max_reg;
        st_s50_next    = st_s50_reg;
        st_s100_next   = st_s100_reg;
        st_s500_next   = st_s500_reg;
        st_s1000_next  = st_s1000_reg;
        rem_next       = rem_reg;
        quo_next       = quo_reg;
        cnt_next       = cnt_reg;
        out_valid_next = out_valid_reg && !rsp.ready;
        out_sec_next   = out_sec_reg;
        out_calls_next = out_calls_reg;
        out_total_next = out_total_reg;
        out_max_next   = out_max_reg;
        out_avg_next   = out_avg_reg;
        out_s50_next   = out_s50_reg;
        out_s100_next  = out_s100_reg;
        out_s500_next  = out_s500_reg;
        out_s1000_next = out_s1000_reg;

        if (cfg_we)
        begin
            enabled_next = cfg_wdata;
        end

        case (state_reg)
            S_IDLE:
            begin
                if (req_fire)
                begin
                    sec_next = req.section;
                    el_next  = req.now_us - req.start_us;
                    case (req.operation)
                        slp_pkg::OP_RECORD:
                        begin
                            if (enabled_reg && (req.start_us != '0) && req_in_range)
                            begin
                                state_next = S_REC_UPD;
                            end
                        end
                        slp_pkg::OP_READ:
                        begin
                            state_next = S_RD_LOAD;
                        end
                        slp_pkg::OP_CLEAR:
                        begin
                            valid_next = '0;
                        end
                        default:
                        begin
                            state_next = S_IDLE;
                        end
                    endcase
                end
            end

            S_REC_UPD:
            begin
                valid_next[sec_reg] = 1'b1;
                state_next          = S_IDLE;
            end

            S_RD_LOAD:
            begin
                st_calls_next = cur_calls;
                st_total_next = cur_total;
                st_max_next   = cur_max;
                st_s50_next   = cur_s50;
                st_s100_next  = cur_s100;
                st_s500_next  = cur_s500;
                st_s1000_next = cur_s1000;
                rem_next      = '0;
                quo_next      = cur_total;
                cnt_next      = '0;
                state_next    = (cur_calls == '0) ? S_FIN : S_DIV;
            end

            S_DIV:
            begin
                rem_next = div_s2;
                quo_next = {quo_reg[TW-3:0], div_ge1, div_ge2};
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == slp_pkg::DIV_CNT_W'(slp_pkg::DIV_STEPS - 1))
                begin
                    state_next = S_FIN;
                end
            end

            S_FIN:
            begin
                if (!out_valid_reg || rsp.ready)
                begin
                    out_valid_next = 1'b1;
                    out_sec_next   = sec_reg;
                    out_calls_next = st_calls_reg;
                    out_total_next = st_total_reg;
                    out_max_next   = st_max_reg;
                    out_avg_next   = (st_calls_reg == '0) ? '0 : quo_reg[CW-1:0];
                    out_s50_next   = st_s50_reg;
                    out_s100_next  = st_s100_reg;
                    out_s500_next  = st_s500_reg;
                    out_s1000_next = st_s1000_reg;
                    state_next     = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // State and registered outputs.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            enabled_reg   <= 1'b1;
            valid_reg     <= '0;
            out_valid_reg <= 1'b0;
            cnt_reg       <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            enabled_reg   <= enabled_next;
            valid_reg     <= valid_next;
            out_valid_reg <= out_valid_next;
            cnt_reg       <= cnt_next;
        end
    end

    // Datapath registers carry no reset.
    always_ff @(posedge clk)
    begin
        sec_reg       <= sec_next;
        el_reg        <= el_next;
        st_calls_reg  <= st_calls_next;
        st_total_reg  <= st_total_next;
        st_max_reg    <= st_max_next;
        st_s50_reg    <= st_s50_next;
        st_s100_reg   <= st_s100_next;
        st_s500_reg   <= st_s500_next;
        st_s1000_reg  <= st_s1000_next;
        rem_reg       <= rem_next;
        quo_reg       <= quo_next;
        out_sec_reg   <= out_sec_next;
        out_calls_reg <= out_calls_next;
        out_total_reg <= out_total_next;
        out_max_reg   <= out_max_next;
        out_avg_reg   <= out_avg_next;
        out_s50_reg   <= out_s50_next;
        out_s100_reg  <= out_s100_next;
        out_s500_reg  <= out_s500_next;
        out_s1000_reg <= out_s1000_next;
    end

    // Record update: one read-modify-write of the section's entry.
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            calls_mem[sec_reg] <= cur_calls + 1'b1;
            total_mem[sec_reg] <= cur_total + {{(TW - CW){1'b0}}, el_reg};
            max_mem[sec_reg]   <= (el_reg > cur_max) ? el_reg : cur_max;
            s50_mem[sec_reg]   <= cur_s50 + CW'(el_reg >= slp_pkg::THRESH_50MS);
            s100_mem[sec_reg]  <= cur_s100 + CW'(el_reg >= slp_pkg::THRESH_100MS);
            s500_mem[sec_reg]  <= cur_s500 + CW'(el_reg >= slp_pkg::THRESH_500MS);
            s1000_mem[sec_reg] <= cur_s1000 + CW'(el_reg >= slp_pkg::THRESH_1000MS);
        end
    end

    // Response channel.
    assign rsp.valid        = out_valid_reg;
    assign rsp.read_section = out_sec_reg;
    assign rsp.call_count   = out_calls_reg;
    assign rsp.total_time   = out_total_reg;
    assign rsp.max_time     = out_max_reg;
    assign rsp.avg_time     = out_avg_reg;
    assign rsp.slow_50ms    = out_s50_reg;
    assign rsp.slow_100ms   = out_s100_reg;
    assign rsp.slow_500ms   = out_s500_reg;
    assign rsp.slow_1000ms  = out_s1000_reg;

endmodule
